// ===== rtl/text_console_scroll_writer_assert.svh =====
// ----------------------------------------------------------------------------
// text_console_scroll_writer assertion macros
// Shared concurrent assertion forms used by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCSW_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tcsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsw_pkg
// Shared constants, types and helpers of the console scroll writer.
// ----------------------------------------------------------------------------
package tcsw_pkg;

   // Screen store geometry
   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);      // column index
   localparam int ROW_W    = $clog2(MAX_ROWS);      // row index
   localparam int COLS_W   = $clog2(MAX_COLS + 1);  // screen width 1..MAX_COLS
   localparam int ROWS_W   = $clog2(MAX_ROWS + 1);  // screen height 1..MAX_ROWS
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(DEPTH);

   // Transaction field widths
   localparam int KIND_W = 2;
   localparam int CHAR_W = 8;
   localparam int RROW_W = 6;
   localparam int RCOL_W = 7;
   localparam int CCOL_W = 7;
   localparam int CROW_W = 6;
   localparam int TOP_W  = 6;

   // One cell: reverse mark above the character byte
   localparam int CELL_W = CHAR_W + 1;

   localparam logic [CHAR_W-1:0] BLANK   = 8'd32;
   localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;
   localparam logic [CELL_W-1:0] CELL_BLANK  = {1'b0, BLANK};
   localparam logic [CELL_W-1:0] CELL_CURSOR = {1'b1, BLANK};

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Classified operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
   localparam logic [OP_W-1:0] OP_BEGIN   = 3'd1;
   localparam logic [OP_W-1:0] OP_CHAR    = 3'd2;
   localparam logic [OP_W-1:0] OP_NEWLINE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ    = 3'd4;

   // Command queue (depth is a power of two)
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Control registers
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int CFG_COLS_W = 8;
   localparam int CFG_ROWS_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS = 1'd1;
   localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;
   localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 7'd25;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] addr;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type cmd;
   } op_slot_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

   typedef struct packed {
      logic [COLS_W-1:0] w;
      logic [ROWS_W-1:0] h;
   } geo_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
   endfunction

endpackage

// ===== rtl/tcsw_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsw channels
// Request and response valid/ready channels of the console scroll writer.
// ----------------------------------------------------------------------------
interface tcsw_req_if;
   import tcsw_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CHAR_W-1:0] char_code;
   logic [RROW_W-1:0] read_row;
   logic [RCOL_W-1:0] read_col;

   modport source (output valid, kind, char_code, read_row, read_col, input ready);
   modport sink   (input valid, kind, char_code, read_row, read_col, output ready);
endinterface

interface tcsw_rsp_if;
   import tcsw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] cell_char;
   logic              cell_reversed;
   logic [CCOL_W-1:0] cursor_col;
   logic [CROW_W-1:0] cursor_row;
   logic [TOP_W-1:0]  region_top;

   modport source (output valid, cell_char, cell_reversed, cursor_col, cursor_row,
                   region_top, input ready);
   modport sink   (input valid, cell_char, cell_reversed, cursor_col, cursor_row,
                   region_top, output ready);
endinterface

// ===== rtl/tcsw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcsw_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcsw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcsw_front
// Accepts request transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module tcsw_front (
   input  logic                    clock,
   input  logic                    reset,
   tcsw_req_if.sink                req_chan,
   input  tcsw_pkg::back_stat_type back_stat,
   output tcsw_pkg::op_slot_type   op_slot
);
   import tcsw_pkg::*;

   op_type               ent_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   op_type               cmd_new;
   logic                 push;
   logic                 in_store;

   // Classify
   always_comb begin
      in_store = (int'(req_chan.read_row) < MAX_ROWS) && (int'(req_chan.read_col) < MAX_COLS);
      cmd_new.char_code = req_chan.char_code;
      cmd_new.addr      = cell_addr(ROW_W'(req_chan.read_row), COL_W'(req_chan.read_col));
      case (req_chan.kind)
         KIND_BEGIN: cmd_new.op = OP_BEGIN;
         KIND_WRITE: cmd_new.op = (req_chan.char_code == NEWLINE) ? OP_NEWLINE : OP_CHAR;
         KIND_READ:  cmd_new.op = in_store ? OP_READ : OP_NOP;
         default:    cmd_new.op = OP_NOP;
      endcase
   end

   // No intake while the screen store is being cleared
   assign req_chan.ready = (count_ff != Q_CNT_W'(Q_DEPTH)) && !back_stat.clearing;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = back_stat.pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      case ({push, back_stat.pop})
         2'b10:   count_in = count_ff + Q_CNT_W'(1);
         2'b01:   count_in = count_ff - Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign op_slot.valid = (count_ff != '0);
   assign op_slot.cmd   = ent_ff[rd_ptr_ff];

endmodule

// ===== rtl/tcsw_back.sv =====
`timescale 1ns / 1ps
`include "text_console_scroll_writer_assert.svh"
// ----------------------------------------------------------------------------
// tcsw_back
// Sequencer that carries out queued operations on the cell store.
// ----------------------------------------------------------------------------
module tcsw_back (
   input  logic                    clock,
   input  logic                    reset,
   input  tcsw_pkg::op_slot_type   op_slot,
   input  tcsw_pkg::geo_type       geo,
   output tcsw_pkg::back_stat_type back_stat,
   tcsw_rsp_if.source              rsp_chan
);
   import tcsw_pkg::*;

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_READ   = 4'd2;
   localparam logic [3:0] ST_CHAR   = 4'd3;
   localparam logic [3:0] ST_TAIL   = 4'd4;
   localparam logic [3:0] ST_ENDL   = 4'd5;
   localparam logic [3:0] ST_COPY   = 4'd6;
   localparam logic [3:0] ST_FLUSH  = 4'd7;
   localparam logic [3:0] ST_BOTTOM = 4'd8;
   localparam logic [3:0] ST_MARK   = 4'd9;
   localparam logic [3:0] ST_RESP   = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ROW_W-1:0]  sr_ff, sr_in;
   logic [COL_W-1:0]  cc_ff, cc_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              nl_ff, nl_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [CHAR_W-1:0] res_char_ff, res_char_in;
   logic              res_rev_ff, res_rev_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_rev_ff, rsp_rev_in;
   logic [CCOL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [CROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [TOP_W-1:0]  rsp_top_ff, rsp_top_in;

   logic              wr_en, rd_en, pop;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CELL_W-1:0] wr_data, rd_data;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;
   logic [ROW_W-1:0]  top_dec;

   tcsw_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign w_last  = COL_W'(geo.w - COLS_W'(1));
   assign h_last  = ROW_W'(geo.h - ROWS_W'(1));
   assign top_dec = (top_ff != '0) ? top_ff - ROW_W'(1) : '0;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      top_in        = top_ff;
      sr_in         = sr_ff;
      cc_in         = cc_ff;
      char_in       = char_ff;
      nl_in         = nl_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      res_char_in   = res_char_ff;
      res_rev_in    = res_rev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_top_in    = rsp_top_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      pop           = 1'b0;

      // second half of a row copy: write back what was read last cycle
      if (pend_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = CELL_BLANK;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (op_slot.valid) begin
               pop         = 1'b1;
               res_char_in = '0;
               res_rev_in  = 1'b0;
               char_in     = op_slot.cmd.char_code;
               nl_in       = (op_slot.cmd.op == OP_NEWLINE);
               case (op_slot.cmd.op)
                  OP_BEGIN: begin
                     row_in   = h_last;
                     top_in   = h_last;
                     col_in   = '0;
                     state_in = ST_RESP;
                  end
                  OP_CHAR, OP_NEWLINE: begin
                     // pull cursor and region top back on screen
                     col_in   = (COLS_W'(col_ff) >= geo.w) ? w_last : col_ff;
                     row_in   = (ROWS_W'(row_ff) >= geo.h) ? h_last : row_ff;
                     top_in   = (ROWS_W'(top_ff) >= geo.h) ? h_last : top_ff;
                     state_in = ST_CHAR;
                  end
                  OP_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = op_slot.cmd.addr;
                     state_in = ST_READ;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_READ: begin
            res_char_in = rd_data[CHAR_W-1:0];
            res_rev_in  = rd_data[CHAR_W];
            state_in    = ST_RESP;
         end
         ST_CHAR: begin
            if (nl_ff) begin
               state_in = ST_TAIL;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cell_addr(row_ff, col_ff);
               wr_data = {1'b0, char_ff};
               if (COLS_W'(col_ff) + COLS_W'(1) >= geo.w) begin
                  state_in = ST_ENDL;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = ST_MARK;
               end
            end
         end
         ST_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(row_ff, col_ff);
            wr_data = CELL_BLANK;
            if (col_ff == w_last) begin
               state_in = ST_ENDL;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_ENDL: begin
            top_in = top_dec;
            col_in = '0;
            cc_in  = '0;
            if (row_ff == h_last) begin
               sr_in = top_dec;
               if (ROWS_W'(top_dec) + ROWS_W'(1) < geo.h) begin
                  state_in = ST_COPY;
               end else begin
                  state_in = ST_BOTTOM;
               end
            end else begin
               row_in   = row_ff + ROW_W'(1);
               state_in = ST_MARK;
            end
         end
         ST_COPY: begin
            // read row sr+1, write it into row sr in the next cycle
            rd_en         = 1'b1;
            rd_addr       = cell_addr(sr_ff + ROW_W'(1), cc_ff);
            pend_valid_in = 1'b1;
            pend_addr_in  = cell_addr(sr_ff, cc_ff);
            if (cc_ff == w_last) begin
               cc_in = '0;
               if (ROWS_W'(sr_ff) + ROWS_W'(2) >= geo.h) begin
                  state_in = ST_FLUSH;
               end else begin
                  sr_in = sr_ff + ROW_W'(1);
               end
            end else begin
               cc_in = cc_ff + COL_W'(1);
            end
         end
         ST_FLUSH: state_in = ST_BOTTOM;
         ST_BOTTOM: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(h_last, cc_ff);
            wr_data = CELL_BLANK;
            if (cc_ff == w_last) begin
               state_in = ST_MARK;
            end else begin
               cc_in = cc_ff + COL_W'(1);
            end
         end
         ST_MARK: begin
            wr_en    = 1'b1;
            wr_addr  = cell_addr(row_ff, col_ff);
            wr_data  = CELL_CURSOR;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_rev_in   = res_rev_ff;
               rsp_col_in   = CCOL_W'(col_ff);
               rsp_row_in   = CROW_W'(row_ff);
               rsp_top_in   = TOP_W'(top_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         top_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         top_ff        <= top_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff        <= sr_in;
      cc_ff        <= cc_in;
      char_ff      <= char_in;
      nl_ff        <= nl_in;
      pend_addr_ff <= pend_addr_in;
      res_char_ff  <= res_char_in;
      res_rev_ff   <= res_rev_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_rev_ff   <= rsp_rev_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_top_ff   <= rsp_top_in;
   end

   assign back_stat.pop      = pop;
   assign back_stat.clearing = (state_ff == ST_CLEAR);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.cell_char     = rsp_char_ff;
   assign rsp_chan.cell_reversed = rsp_rev_ff;
   assign rsp_chan.cursor_col    = rsp_col_ff;
   assign rsp_chan.cursor_row    = rsp_row_ff;
   assign rsp_chan.region_top    = rsp_top_ff;

   `TCSW_ASSERT_IMPLIES(a_pend_in_copy, clock, reset, pend_valid_ff,
      (state_ff == ST_COPY) || (state_ff == ST_FLUSH), "row copy write outside scroll")
   `TCSW_ASSERT_IMPLIES(a_mark_on_screen, clock, reset, state_ff == ST_MARK,
      (COLS_W'(col_ff) < geo.w) && (ROWS_W'(row_ff) < geo.h), "cursor off screen")
   `TCSW_ASSERT_IMPLIES(a_copy_src_on_screen, clock, reset, state_ff == ST_COPY,
      ROWS_W'(sr_ff) + ROWS_W'(1) < geo.h, "scroll source row off screen")
   `TCSW_ASSERT_IMPLIES(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_RESP, "response raised outside response step")
   `TCSW_ASSERT_NEXT(a_flush_to_bottom, clock, reset, state_ff == ST_FLUSH,
      (state_ff == ST_BOTTOM) && !pend_valid_ff, "scroll did not drain")

endmodule

// ===== rtl/text_console_scroll_writer.sv =====
// Steps: a newline blanks the rest of its row; at the bottom row a line end moves the rows
//   below the moved-up region top up by one row, then blanks the bottom row.
// Throughput: one transaction at a time in the back sequencer; a scroll moves one cell/cycle.
// Reset: synchronous; a clearing pass blanks the cell store, during which
//   no request is taken (control register writes are still taken).
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_scroll_writer
// Character cell console writer with a growing scroll region.
// ----------------------------------------------------------------------------
module text_console_scroll_writer (
   input  logic                             clock,
   input  logic                             reset,
   tcsw_req_if.sink                         req_chan,
   tcsw_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [tcsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcsw_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tcsw_pkg::*;

   // Screen size registers as written by software
   logic [CFG_COLS_W-1:0] cols_ff, cols_in;
   logic [CFG_ROWS_W-1:0] rows_ff, rows_in;

   geo_type       geo;
   op_slot_type   op_slot;
   back_stat_type back_stat;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         case (csr_index)
            REG_COLS: cols_in = csr_wdata[CFG_COLS_W-1:0];
            REG_ROWS: rows_in = csr_wdata[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Clamp width to 1..MAX_COLS and height to 1..MAX_ROWS before use
   always_comb begin
      if (cols_ff == '0) begin
         geo.w = COLS_W'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         geo.w = COLS_W'(MAX_COLS);
      end else begin
         geo.w = COLS_W'(cols_ff);
      end
      if (rows_ff == '0) begin
         geo.h = ROWS_W'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         geo.h = ROWS_W'(MAX_ROWS);
      end else begin
         geo.h = ROWS_W'(rows_ff);
      end
   end

   // Front: takes request transactions, classifies and queues them
   tcsw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .back_stat (back_stat),
      .op_slot   (op_slot)
   );

   // Back: cell store, cursor state, scroll sequencer and response register
   tcsw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_slot   (op_slot),
      .geo       (geo),
      .back_stat (back_stat),
      .rsp_chan  (rsp_chan)
   );

endmodule
